// ----- hw/rtl/tsb_pkg.sv -----
// Shared types and constants for the bilinear texture sampler.
package tsb_pkg;

   localparam int MaxSizeLog2 = 8;

   localparam int CsrAddrW = 4;
   localparam logic [CsrAddrW-1:0] CsrAddrWrap   = 4'h0;
   localparam logic [CsrAddrW-1:0] CsrAddrWidth  = 4'h4;
   localparam logic [CsrAddrW-1:0] CsrAddrHeight = 4'h8;

   typedef enum logic [1:0] {
      CMD_WRITE    = 2'd0,
      CMD_NEAREST  = 2'd1,
      CMD_BILINEAR = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   // Back part sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_RD0  = 5'b00010,
      ST_RD1  = 5'b00100,
      ST_RD2  = 5'b01000,
      ST_RD3  = 5'b10000
   } bst_type;

endpackage

// ----- hw/rtl/texture_sampler_bilinear.sv -----
// Top level of the bilinear texture sampler.
// One item is taken at a rising edge with start high and busy low. A write and a
// nearest sample each make one access to the single-port texture memory and a bilinear
// sample four, one per neighbor, so writes and nearest samples stream at one per cycle
// while no bilinear sample holds the back part; an item queued behind a bilinear sample
// is taken in its last sequencer state, ST_RD3. A result passes through the front output
// register, the memory read register and the result register, a bilinear one after its
// four neighbor reads. Busy is high while the front register holds an item that the back
// part cannot take yet. Results cannot be held off by the receiver: each is on the
// rsp_ ports for exactly one cycle.
module texture_sampler_bilinear #(
   parameter int MaxSizeLog2 = tsb_pkg::MaxSizeLog2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_u_coord,
   input  logic signed [31:0] req_v_coord,
   input  logic [7:0]         req_texel_x,
   input  logic [7:0]         req_texel_y,
   input  logic [7:0]         req_red,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_blue,
   input  logic [7:0]         req_alpha,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_out_red,
   output logic [7:0]         rsp_out_green,
   output logic [7:0]         rsp_out_blue,
   output logic [7:0]         rsp_out_alpha,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [tsb_pkg::CsrAddrW-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int AddrW = 2 * MaxSizeLog2;

   logic       wrap_ff;
   logic [3:0] wl_ff, hl_ff;
   logic       f_valid, b_ready, b_valid;
   logic [1:0] f_kind;
   logic [AddrW-1:0] a00, a10, a01, a11;
   logic [7:0] fx, fy;
   logic [31:0] f_rgba, b_rgba;
   logic       accept;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff <= 1'b0;
         wl_ff   <= 4'd8;
         hl_ff   <= 4'd8;
      end else if (psel && penable && pwrite) begin
         unique case (paddr)
            tsb_pkg::CsrAddrWrap:   wrap_ff <= pwdata[0];
            tsb_pkg::CsrAddrWidth:  wl_ff   <= pwdata[3:0];
            tsb_pkg::CsrAddrHeight: hl_ff   <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr)
         tsb_pkg::CsrAddrWrap:   prdata = {31'd0, wrap_ff};
         tsb_pkg::CsrAddrWidth:  prdata = {28'd0, wl_ff};
         tsb_pkg::CsrAddrHeight: prdata = {28'd0, hl_ff};
         default:                prdata = '0;
      endcase
   end

   // front holds one item in its output register; take a new one only if it is empty
   // or the back takes that one this cycle
   assign busy   = f_valid && !b_ready;
   assign accept = start && !busy;

   tsb_front #(.MaxLog2(MaxSizeLog2)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .in_cmd      (tsb_pkg::cmd_type'(req_cmd)),
      .in_u        (req_u_coord),
      .in_v        (req_v_coord),
      .in_x        (req_texel_x),
      .in_y        (req_texel_y),
      .in_rgba     ({req_alpha, req_blue, req_green, req_red}),
      .wrap_mode   (wrap_ff),
      .width_log2  (wl_ff),
      .height_log2 (hl_ff),
      .out_ready   (b_ready),
      .out_valid   (f_valid),
      .out_kind    (f_kind),
      .out_a00     (a00),
      .out_a10     (a10),
      .out_a01     (a01),
      .out_a11     (a11),
      .out_fx      (fx),
      .out_fy      (fy),
      .out_rgba    (f_rgba)
   );

   tsb_back #(.MaxLog2(MaxSizeLog2)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_kind   (f_kind),
      .in_a00    (a00),
      .in_a10    (a10),
      .in_a01    (a01),
      .in_a11    (a11),
      .in_fx     (fx),
      .in_fy     (fy),
      .in_rgba   (f_rgba),
      .in_ready  (b_ready),
      .rsp_valid (b_valid),
      .rsp_rgba  (b_rgba)
   );

   assign rsp_strobe    = b_valid;
   assign rsp_out_red   = b_rgba[7:0];
   assign rsp_out_green = b_rgba[15:8];
   assign rsp_out_blue  = b_rgba[23:16];
   assign rsp_out_alpha = b_rgba[31:24];

endmodule

// ----- hw/rtl/tsb_ram.sv -----
// Generic single-port RAM with registered read.
module tsb_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/tsb_front.sv -----
// Front part: scales coordinates, splits index and fraction, wraps or clamps the four neighbors.
module tsb_front #(
   parameter int MaxLog2 = tsb_pkg::MaxSizeLog2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  tsb_pkg::cmd_type       in_cmd,
   input  logic signed [31:0]     in_u,
   input  logic signed [31:0]     in_v,
   input  logic [7:0]             in_x,
   input  logic [7:0]             in_y,
   input  logic [31:0]            in_rgba,
   input  logic                   wrap_mode,
   input  logic [3:0]             width_log2,
   input  logic [3:0]             height_log2,
   input  logic                   out_ready,
   output logic                   out_valid,
   output logic [1:0]             out_kind,   // 0 write, 1 nearest, 2 bilinear
   output logic [2*MaxLog2-1:0]   out_a00,
   output logic [2*MaxLog2-1:0]   out_a10,
   output logic [2*MaxLog2-1:0]   out_a01,
   output logic [2*MaxLog2-1:0]   out_a11,
   output logic [7:0]             out_fx,
   output logic [7:0]             out_fy,
   output logic [31:0]            out_rgba
);

   localparam int IdxW = 32 + MaxLog2 - 16 + 1;

   logic [3:0] wl, hl;
   logic signed [47:0] s_q, t_q, sp_q, tp_q;
   logic signed [IdxW-1:0] ix, iy, ix1, iy1;
   logic [MaxLog2-1:0] wx0, wx1, wy0, wy1, mx, my;
   logic load;

   logic                 valid_ff;
   logic [1:0]           kind_ff;
   logic [2*MaxLog2-1:0] a00_ff, a10_ff, a01_ff, a11_ff;
   logic [7:0]           fx_ff, fy_ff;
   logic [31:0]          rgba_ff;

   function automatic logic [MaxLog2-1:0] wrap_fn(input logic signed [IdxW-1:0] i,
                                                  input logic [3:0] lg, input logic rep);
      logic signed [IdxW-1:0] size;
      logic [MaxLog2-1:0] r;
      size = IdxW'(1) <<< lg;
      if (rep) begin
         r = MaxLog2'(i & (size - IdxW'(1)));
      end else if (i < 0) begin
         r = '0;
      end else if (i >= size) begin
         r = MaxLog2'(size - IdxW'(1));
      end else begin
         r = MaxLog2'(i);
      end
      return r;
   endfunction

   always_comb begin
      wl = (width_log2 > 4'(MaxLog2)) ? 4'(MaxLog2) : width_log2;
      hl = (height_log2 > 4'(MaxLog2)) ? 4'(MaxLog2) : height_log2;
      s_q = 48'(in_u) <<< wl;
      t_q = 48'(in_v) <<< hl;
      sp_q = (in_cmd == tsb_pkg::CMD_BILINEAR) ? s_q - 48'sd32768 : s_q;
      tp_q = (in_cmd == tsb_pkg::CMD_BILINEAR) ? t_q - 48'sd32768 : t_q;
      ix = IdxW'(sp_q >>> 16);
      iy = IdxW'(tp_q >>> 16);
      ix1 = ix + IdxW'(1);
      iy1 = iy + IdxW'(1);
      wx0 = wrap_fn(ix, wl, wrap_mode);
      wx1 = wrap_fn(ix1, wl, wrap_mode);
      wy0 = wrap_fn(iy, hl, wrap_mode);
      wy1 = wrap_fn(iy1, hl, wrap_mode);
      mx = MaxLog2'(in_x);
      my = MaxLog2'(in_y);
   end

   // output register holds its beat until the back part takes it
   assign load = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid && (in_cmd != tsb_pkg::CMD_UNUSED);
      end
      if (load) begin
         unique case (in_cmd)
            tsb_pkg::CMD_WRITE: begin
               kind_ff <= tsb_pkg::CMD_WRITE;
               a00_ff  <= {my, mx};
            end
            tsb_pkg::CMD_NEAREST: begin
               kind_ff <= tsb_pkg::CMD_NEAREST;
               a00_ff  <= {wy0, wx0};
            end
            default: begin
               kind_ff <= tsb_pkg::CMD_BILINEAR;
               a00_ff  <= {wy0, wx0};
            end
         endcase
         a10_ff  <= {wy0, wx1};
         a01_ff  <= {wy1, wx0};
         a11_ff  <= {wy1, wx1};
         fx_ff   <= sp_q[15:8];
         fy_ff   <= tp_q[15:8];
         rgba_ff <= in_rgba;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_a00   = a00_ff;
   assign out_a10   = a10_ff;
   assign out_a01   = a01_ff;
   assign out_a11   = a11_ff;
   assign out_fx    = fx_ff;
   assign out_fy    = fy_ff;
   assign out_rgba  = rgba_ff;

endmodule

// ----- hw/rtl/tsb_back.sv -----
// Back part: texture memory writes and reads, weighted accumulation for bilinear samples.
module tsb_back #(
   parameter int MaxLog2 = tsb_pkg::MaxSizeLog2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [1:0]           in_kind,
   input  logic [2*MaxLog2-1:0] in_a00,
   input  logic [2*MaxLog2-1:0] in_a10,
   input  logic [2*MaxLog2-1:0] in_a01,
   input  logic [2*MaxLog2-1:0] in_a11,
   input  logic [7:0]           in_fx,
   input  logic [7:0]           in_fy,
   input  logic [31:0]          in_rgba,
   output logic                 in_ready,
   output logic                 rsp_valid,
   output logic [31:0]          rsp_rgba
);

   localparam int AddrW = 2 * MaxLog2;

   tsb_pkg::bst_type st_ff, st_in;
   logic [AddrW-1:0] a10_ff, a01_ff, a11_ff, addr;
   logic [8:0] wx0_ff, wx1_ff, wy0_ff, wy1_ff;
   logic [31:0] rd;
   logic [17:0] w_cur;
   logic [8:0] wa, wb;
   logic [25:0] acc_ff [4];
   logic [25:0] acc_in [4];
   logic [25:0] tot [4];
   logic rd_v_ff, last_ff, rd_near_ff, first_ff;
   logic [17:0] w_ff;
   logic out_v_ff;
   logic [31:0] out_ff;
   logic wr_en;

   // accept a new item only when idle or in ST_RD3; a bilinear item steps through ST_RD0 to ST_RD3
   assign in_ready = (st_ff == tsb_pkg::ST_IDLE) || (st_ff == tsb_pkg::ST_RD3);
   assign wr_en = in_valid && in_ready && (in_kind == tsb_pkg::CMD_WRITE);

   always_comb begin
      st_in = st_ff;
      addr = in_a00;
      unique case (st_ff)
         tsb_pkg::ST_IDLE, tsb_pkg::ST_RD3: begin
            st_in = (in_valid && in_kind == tsb_pkg::CMD_BILINEAR) ?
                    tsb_pkg::ST_RD0 : tsb_pkg::ST_IDLE;
            addr = in_a00;
         end
         tsb_pkg::ST_RD0: begin
            st_in = tsb_pkg::ST_RD1;
            addr = a10_ff;
         end
         tsb_pkg::ST_RD1: begin
            st_in = tsb_pkg::ST_RD2;
            addr = a01_ff;
         end
         tsb_pkg::ST_RD2: begin
            st_in = tsb_pkg::ST_RD3;
            addr = a11_ff;
         end
         default: begin
            st_in = tsb_pkg::ST_IDLE;
            addr = in_a00;
         end
      endcase
      unique case (st_ff)
         tsb_pkg::ST_RD0: begin
            wa = wx1_ff;
            wb = wy0_ff;
         end
         tsb_pkg::ST_RD1: begin
            wa = wx0_ff;
            wb = wy1_ff;
         end
         tsb_pkg::ST_RD2: begin
            wa = wx1_ff;
            wb = wy1_ff;
         end
         default: begin
            wa = 9'd256 - {1'b0, in_fx};
            wb = 9'd256 - {1'b0, in_fy};
         end
      endcase
      w_cur = wa * wb;
   end

   tsb_ram #(.Width(32), .Depth(1 << AddrW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (addr),
      .wr_data (in_rgba),
      .rd_data (rd)
   );

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         acc_in[c] = (first_ff ? 26'd0 : acc_ff[c]) + 26'(rd[8*c +: 8]) * 26'(w_ff);
         tot[c] = acc_in[c] + 26'd32768;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= tsb_pkg::ST_IDLE;
         rd_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         rd_v_ff <= (in_ready && in_valid && in_kind != tsb_pkg::CMD_WRITE) ||
                    (st_ff != tsb_pkg::ST_IDLE && st_ff != tsb_pkg::ST_RD3);
         out_v_ff <= rd_v_ff && last_ff;
      end
      if (in_ready && in_valid) begin
         a10_ff <= in_a10;
         a01_ff <= in_a01;
         a11_ff <= in_a11;
         wx0_ff <= 9'd256 - {1'b0, in_fx};
         wx1_ff <= {1'b0, in_fx};
         wy0_ff <= 9'd256 - {1'b0, in_fy};
         wy1_ff <= {1'b0, in_fy};
      end
      first_ff   <= in_ready;
      rd_near_ff <= in_ready && in_kind == tsb_pkg::CMD_NEAREST;
      last_ff    <= (in_ready && in_kind == tsb_pkg::CMD_NEAREST) ||
                    (st_ff == tsb_pkg::ST_RD2);
      w_ff       <= w_cur;
      for (int c = 0; c < 4; c++) begin
         acc_ff[c] <= acc_in[c];
      end
      if (rd_v_ff && last_ff) begin
         for (int c = 0; c < 4; c++) begin
            out_ff[8*c +: 8] <= rd_near_ff ? rd[8*c +: 8] : tot[c][23:16];
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_rgba  = out_ff;

`ifndef NO_ASSERTIONS
   a_no_write_in_burst: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> in_ready) else $error("write during bilinear burst");
   a_rd3_after_rd2: assert property (@(posedge clock) disable iff (reset)
      st_ff == tsb_pkg::ST_RD2 |=> st_ff == tsb_pkg::ST_RD3)
      else $error("sequencer skipped");
   a_state_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(st_ff))
      else $error("state not one-hot");
`endif

endmodule
